// ===== hdl/tdp_pkg.sv =====
`timescale 1ns / 1ps

package tdp_pkg;

  // fraction digits kept after the point
  localparam int FRAC_DIGITS = 6;

  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam longint FRAC_DEN = pow10(FRAC_DIGITS);
  localparam int     REM_W    = $clog2(FRAC_DEN);
  localparam int     CNT_W    = $clog2(FRAC_DIGITS + 1);
  localparam int     POS_W    = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam logic [REM_W:0]   DEN_EXT  = (REM_W + 1)'(FRAC_DEN);
  localparam logic [REM_W-1:0] ROUND_AT = REM_W'(FRAC_DEN - FRAC_DEN / 2);
  localparam logic [14:0]      INT_MAX  = 15'h7fff;

  // characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_POINT = 8'h2e;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Y     = 8'h59;

  localparam logic [2:0][7:0] TAG_CHARS = {CH_Y, CH_P, CH_R};

  // per digit position and digit value: the weight d * 65536 / 10^(pos+1)
  // split into a whole part and a remainder in units of 1 / FRAC_DEN
  typedef logic [FRAC_DIGITS-1:0][9:0][15:0]      frac_q_tab_t;
  typedef logic [FRAC_DIGITS-1:0][9:0][REM_W-1:0] frac_r_tab_t;

  function automatic frac_q_tab_t build_frac_q();
    frac_q_tab_t tab;
    longint      v;
    tab = '0;
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      for (int d = 0; d < 10; d++) begin
        v = longint'(d) * 65536;
        for (int i = 0; i <= k; i++) begin
          v = v / 10;
        end
        tab[k][d] = v[15:0];
      end
    end
    return tab;
  endfunction

  function automatic frac_r_tab_t build_frac_r();
    frac_r_tab_t tab;
    longint      v;
    longint      t;
    tab = '0;
    for (int k = 0; k < FRAC_DIGITS; k++) begin
      for (int d = 0; d < 10; d++) begin
        v = longint'(d) * 65536;
        for (int i = 0; i <= k; i++) begin
          v = v / 10;
        end
        t = longint'(d) * 65536 * pow10(FRAC_DIGITS - 1 - k) - v * FRAC_DEN;
        tab[k][d] = t[REM_W-1:0];
      end
    end
    return tab;
  endfunction

  localparam frac_q_tab_t FRAC_Q_TAB = build_frac_q();
  localparam frac_r_tab_t FRAC_R_TAB = build_frac_r();

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] roll_q16;
    logic signed [31:0] pitch_q16;
    logic signed [31:0] yaw_q16;
  } out_item_t;

  // one tag parser's view of its number
  typedef struct packed {
    logic             ok;
    logic             neg;
    logic [14:0]      intg;
    logic [15:0]      frac_q;
    logic [REM_W-1:0] frac_r;
  } tag_snap_t;

  typedef struct packed {
    logic parse_en;
    logic clear;
  } tag_ctl_t;

endpackage

// ===== hdl/tdp_tag.sv =====
`timescale 1ns / 1ps

module tdp_tag (
  input  logic              clk,
  input  logic              rst_n,
  input  tdp_pkg::tag_ctl_t ctl,
  input  logic [7:0]        chr,
  input  logic [7:0]        prev_chr,
  input  logic [7:0]        tag_char,
  output tdp_pkg::tag_snap_t snap
);
  import tdp_pkg::*;

  localparam logic [2:0] PH_SEARCH    = 3'd0;
  localparam logic [2:0] PH_AFTER_TAG = 3'd1;
  localparam logic [2:0] PH_AFTER_SGN = 3'd2;
  localparam logic [2:0] PH_INT       = 3'd3;
  localparam logic [2:0] PH_FRAC      = 3'd4;
  localparam logic [2:0] PH_DONE      = 3'd5;
  localparam logic [2:0] PH_FAIL      = 3'd6;

  logic [2:0]       phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [14:0]      int_r, int_nxt;
  logic [15:0]      fq_r, fq_nxt;
  logic [REM_W-1:0] fr_r, fr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             is_digit;
  logic [3:0]       dig;
  logic [18:0]      int_prod;
  logic [POS_W-1:0] pos;
  logic [REM_W:0]   r_sum;
  logic [15:0]      q_sum;

  always_comb begin
    is_digit = (chr >= CH_D0) && (chr <= CH_D9);
    dig      = is_digit ? chr[3:0] : 4'd0;
    int_prod = 19'({int_r, 3'b000}) + 19'({int_r, 1'b0}) + 19'(dig);
    pos      = cnt_r[POS_W-1:0];
    r_sum    = {1'b0, fr_r} + {1'b0, FRAC_R_TAB[pos][dig]};
    q_sum    = fq_r + FRAC_Q_TAB[pos][dig];
  end

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_nxt   = int_r;
    fq_nxt    = fq_r;
    fr_nxt    = fr_r;
    cnt_nxt   = cnt_r;
    if (ctl.parse_en) begin
      case (phase_r)
        PH_SEARCH: begin
          if (prev_chr == tag_char && chr == CH_COLON) begin
            phase_nxt = PH_AFTER_TAG;
          end
        end
        PH_AFTER_TAG: begin
          if (chr == CH_PLUS) begin
            phase_nxt = PH_AFTER_SGN;
          end else if (chr == CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_AFTER_SGN;
          end else if (is_digit) begin
            int_nxt   = 15'(dig);
            phase_nxt = PH_INT;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_AFTER_SGN: begin
          if (is_digit) begin
            int_nxt   = 15'(dig);
            phase_nxt = PH_INT;
          end else begin
            phase_nxt = PH_FAIL;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            int_nxt = (int_prod > 19'(INT_MAX)) ? INT_MAX : int_prod[14:0];
          end else if (chr == CH_POINT) begin
            phase_nxt = PH_FRAC;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (cnt_r < CNT_W'(FRAC_DIGITS)) begin
              // remainder stays below twice the denominator
              if (r_sum >= DEN_EXT) begin
                fr_nxt = REM_W'(r_sum - DEN_EXT);
                fq_nxt = q_sum + 16'd1;
              end else begin
                fr_nxt = r_sum[REM_W-1:0];
                fq_nxt = q_sum;
              end
              cnt_nxt = cnt_r + CNT_W'(1);
            end
          end else begin
            phase_nxt = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      phase_r <= PH_SEARCH;
      neg_r   <= 1'b0;
      int_r   <= '0;
      fq_r    <= '0;
      fr_r    <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      int_r   <= int_nxt;
      fq_r    <= fq_nxt;
      fr_r    <= fr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    snap.ok     = (phase_nxt == PH_INT) || (phase_nxt == PH_FRAC) || (phase_nxt == PH_DONE);
    snap.neg    = neg_nxt;
    snap.intg   = int_nxt;
    snap.frac_q = fq_nxt;
    snap.frac_r = fr_nxt;
  end

endmodule

// ===== hdl/tdp_conv.sv =====
`timescale 1ns / 1ps

module tdp_conv (
  input  tdp_pkg::tag_snap_t snap,
  input  logic               ok_all,
  output logic signed [31:0] q16
);
  import tdp_pkg::*;

  logic [16:0] fq;
  logic [31:0] mag;

  always_comb begin
    // round to nearest, ties up
    fq  = {1'b0, snap.frac_q} + ((snap.frac_r >= ROUND_AT) ? 17'd1 : 17'd0);
    mag = {1'b0, snap.intg, 16'h0000} + 32'(fq);
    if (!ok_all) begin
      q16 = '0;
    end else if (snap.neg) begin
      q16 = $signed(32'd0 - mag);
    end else if (mag[31]) begin
      q16 = 32'sh7fffffff;
    end else begin
      q16 = $signed(mag);
    end
  end

endmodule

// ===== hdl/tagged_decimal_triple_parser_core.sv =====
`timescale 1ns / 1ps

// result path: the transaction carrying the end of the string is snapshotted, then converted into the output register
// throughput: one character per cycle while out_ready back-pressure does not stall the pipeline through in_ready
// stages: input register, tag state update with result snapshot, conversion into output register
// reset: rst_n synchronous, active low; clears tag state, string flags and all valid bits
// a last-flagged character returns all parser state to reset as it is consumed
module tagged_decimal_triple_parser_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tdp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tdp_pkg::out_item_t  out_data
);
  import tdp_pkg::*;

  // input register
  in_item_t  in_r;
  logic      in_valid_r;

  // message level state
  logic [7:0] prev_r;
  logic       ended_r;

  // snapshot register between the parsers and the converters
  tag_snap_t emt_snap_r [3];
  logic      emt_valid_r;

  // result register
  out_item_t out_r;
  logic      out_valid_r;

  logic      c_free;
  logic      b_free;
  logic      a_fire;
  logic      is_nul;
  logic      emit;
  logic      msg_clear;
  tag_ctl_t  tag_ctl;
  tag_snap_t snap_nxt [3];
  logic      ok_all;
  logic signed [31:0] conv_q16 [3];

  // ready ripples back from the result side; each stage frees when its successor can take it
  always_comb begin
    c_free   = !out_valid_r || out_ready;
    b_free   = !emt_valid_r || c_free;
    in_ready = !in_valid_r || b_free;
    a_fire   = in_valid_r && b_free;
  end

  always_comb begin
    is_nul = (in_r.char_byte == CH_NUL);
    // a nul byte finishes the message without being parsed
    emit = a_fire && !ended_r && (is_nul || in_r.last);
    // after a nul, bytes are dropped until the last-flagged one
    msg_clear = a_fire && in_r.last;
    tag_ctl.parse_en = a_fire && !ended_r && !is_nul;
    tag_ctl.clear    = msg_clear;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || msg_clear) begin
      prev_r  <= '0;
      ended_r <= 1'b0;
    end else if (a_fire && !ended_r) begin
      if (is_nul) begin
        ended_r <= 1'b1;
      end else begin
        prev_r <= in_r.char_byte;
      end
    end
  end

  // three tag parsers see every character side by side
  for (genvar t = 0; t < 3; t++) begin : g_tag
    tdp_tag u_tag (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (tag_ctl),
      .chr      (in_r.char_byte),
      .prev_chr (prev_r),
      .tag_char (TAG_CHARS[t]),
      .snap     (snap_nxt[t])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emt_valid_r <= 1'b0;
    end else if (emit) begin
      emt_valid_r <= 1'b1;
    end else if (c_free) begin
      emt_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int t = 0; t < 3; t++) begin
        emt_snap_r[t] <= snap_nxt[t];
      end
    end
  end

  // fixed point conversion, one converter per tag
  assign ok_all = emt_snap_r[0].ok && emt_snap_r[1].ok && emt_snap_r[2].ok;

  for (genvar t = 0; t < 3; t++) begin : g_conv
    tdp_conv u_conv (
      .snap   (emt_snap_r[t]),
      .ok_all (ok_all),
      .q16    (conv_q16[t])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_free) begin
      out_valid_r <= emt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_free && emt_valid_r) begin
      out_r.ok        <= ok_all;
      out_r.roll_q16  <= conv_q16[0];
      out_r.pitch_q16 <= conv_q16[1];
      out_r.yaw_q16   <= conv_q16[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
